>>> hdl/virtual_region_table_macros.svh
`ifndef VIRTUAL_REGION_TABLE_MACROS_SVH
`define VIRTUAL_REGION_TABLE_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define VRT_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error("region table check failed");

// Next-cycle implication, disabled while reset is low.
`define VRT_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error("region table check failed");

`endif

>>> hdl/vrt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package vrt_pkg;

  localparam int MAX_REGIONS_DEF = 64;
  localparam int PAGE_BYTES_DEF  = 4096;

  localparam logic [31:0] USER_LIMIT = 32'hBFFF_FFFF;

  // request kinds carried on in_tuser
  localparam logic [1:0] FN_MAP   = 2'd0;
  localparam logic [1:0] FN_UNMAP = 2'd1;
  localparam logic [1:0] FN_FAULT = 2'd2;

  // result status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BADSIZE  = 3'd1;
  localparam logic [2:0] ST_NOSPACE  = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;
  localparam logic [2:0] ST_DENIED   = 3'd5;
  localparam logic [2:0] ST_MAPPED   = 3'd6;

  localparam logic [2:0] PROT_WRITE  = 3'h2;
  localparam logic [2:0] PROT_USER   = 3'h4;
  localparam logic [2:0] PTE_PRESENT = 3'h1;

  // update broadcast to every cell of the table
  typedef enum logic [2:0] {
    OP_NONE,
    OP_INSERT,
    OP_DROP,
    OP_TRIM_FRONT,
    OP_TRIM_BACK
  } op_t;

  function automatic logic [2:0] pte_of(input logic [2:0] prot);
    pte_of = PTE_PRESENT | (prot & (PROT_WRITE | PROT_USER));
  endfunction

endpackage

`default_nettype wire

>>> hdl/virtual_region_table.sv
//  channel | direction | tdata (low bit up)                         | tuser
//  in_     | slave     | addr 32, size 32, prot 3, wr_fault, present | func 2
//  out_    | master    | status 3, result_addr 32, page_flags 3      | -
//
//  out_tvalid rises once a request has passed S_EVAL and then S_DONE, which
//  loads the output register; a map with automatic placement passes S_SCAN
//  between them: the candidate start walks the chain of cells one cell per cycle.
//  Requests do not overlap: the next in_ beat is taken only back in S_IDLE,
//  and in_tready is high only while idle.
//  rst_n (synchronous) empties the table; no clearing pass is needed.
//  A stalled result holds in the output register until out_tready.
`timescale 1ns / 1ps
`default_nettype none

module virtual_region_table #(
  parameter int MAX_REGIONS = vrt_pkg::MAX_REGIONS_DEF,
  parameter int PAGE_BYTES  = vrt_pkg::PAGE_BYTES_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [71:0] in_tdata,   // addr, size, prot, write_fault, page_present, pad
  input  wire  [1:0]  in_tuser,   // func
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [39:0] out_tdata   // status, result_addr, page_flags, pad
);

  localparam int PS = $clog2(PAGE_BYTES);
  localparam int PW = 32 - PS;
  localparam int CW = $clog2(MAX_REGIONS + 1);
  localparam logic [PW+1:0] LIM_PG  = (PW+2)'((64'(vrt_pkg::USER_LIMIT) + 64'd1) >> PS);
  localparam logic [PW+1:0] SPAN_PG = (PW+2)'(64'h1_0000_0000 >> PS);

  typedef enum logic [1:0] {S_IDLE, S_EVAL, S_SCAN, S_DONE} state_t;

  state_t        state_r, state_nxt;

  // request held for the whole operation
  logic [1:0]    func_r;
  logic [PW-1:0] s_r;
  logic [PW:0]   npg_r;
  logic [2:0]    prot_r;
  logic          wf_r, pp_r, size_zero_r, addr_zero_r;

  logic [2:0]    res_status_r, res_status_nxt;
  logic [31:0]   res_addr_r, res_addr_nxt;
  logic [2:0]    res_pte_r, res_pte_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [2:0]    out_status_r;
  logic [31:0]   out_addr_r;
  logic [2:0]    out_pte_r;
  logic [CW-1:0] count_r, count_nxt;

  logic          in_beat;
  logic [32:0]   size_up;

  // cell chain signals
  vrt_pkg::op_t  cell_op;
  logic [PW-1:0] req_page;
  logic [PW:0]   req_end;
  logic          scan_go;

  logic          c_valid [MAX_REGIONS];
  logic [PW-1:0] c_start [MAX_REGIONS];
  logic [PW:0]   c_end   [MAX_REGIONS];
  logic [2:0]    c_prot  [MAX_REGIONS];
  logic          c_shift [MAX_REGIONS];
  logic          c_hit   [MAX_REGIONS];
  logic          c_ovl   [MAX_REGIONS];
  logic          c_tok   [MAX_REGIONS];
  logic [PW:0]   c_cand  [MAX_REGIONS];

  logic          hit_any, ovl_any;
  logic [PW-1:0] hit_start;
  logic [PW:0]   hit_end;
  logic [2:0]    hit_prot;

  assign in_tready = (state_r == S_IDLE);
  assign in_beat   = in_tvalid && in_tready;
  assign size_up   = {1'b0, in_tdata[63:32]} + 33'(PAGE_BYTES - 1);

  genvar g;
  generate
    for (g = 0; g < MAX_REGIONS; g++) begin : g_cell
      logic          lv, ls_f, rv, tok_in;
      logic [PW-1:0] ls, rs;
      logic [PW:0]   le, re, cin;
      logic [2:0]    lp, rp;
      if (g == 0) begin : g_head
        assign lv     = 1'b0;
        assign ls     = '0;
        assign le     = '0;
        assign lp     = '0;
        assign ls_f   = 1'b0;
        assign tok_in = scan_go;
        assign cin    = (PW+1)'(1);
      end else begin : g_body
        assign lv     = c_valid[g-1];
        assign ls     = c_start[g-1];
        assign le     = c_end[g-1];
        assign lp     = c_prot[g-1];
        assign ls_f   = c_shift[g-1];
        assign tok_in = c_tok[g-1];
        assign cin    = c_cand[g-1];
      end
      if (g == MAX_REGIONS - 1) begin : g_tail
        assign rv = 1'b0;
        assign rs = '0;
        assign re = '0;
        assign rp = '0;
      end else begin : g_mid
        assign rv = c_valid[g+1];
        assign rs = c_start[g+1];
        assign re = c_end[g+1];
        assign rp = c_prot[g+1];
      end
      vrt_cell #(.PW(PW)) u_cell (
        .clk          (clk),
        .rst_n        (rst_n),
        .op           (cell_op),
        .req_page     (req_page),
        .req_end      (req_end),
        .req_npg      (npg_r),
        .req_prot     (prot_r),
        .l_valid      (lv),
        .l_start      (ls),
        .l_end        (le),
        .l_prot       (lp),
        .l_shift      (ls_f),
        .r_valid      (rv),
        .r_start      (rs),
        .r_end        (re),
        .r_prot       (rp),
        .cand_tok_in  (tok_in),
        .cand_in      (cin),
        .cell_valid   (c_valid[g]),
        .cell_start   (c_start[g]),
        .cell_end     (c_end[g]),
        .cell_prot    (c_prot[g]),
        .cell_shift   (c_shift[g]),
        .cell_hit     (c_hit[g]),
        .cell_ovl     (c_ovl[g]),
        .cand_tok_out (c_tok[g]),
        .cand_out     (c_cand[g])
      );
    end
  endgenerate

  // regions are disjoint, so at most one cell hits: OR the hit cell's fields
  always_comb begin
    hit_any   = 1'b0;
    ovl_any   = 1'b0;
    hit_start = '0;
    hit_end   = '0;
    hit_prot  = '0;
    for (int i = 0; i < MAX_REGIONS; i++) begin
      hit_any   = hit_any | c_hit[i];
      ovl_any   = ovl_any | c_ovl[i];
      hit_start = hit_start | (c_start[i] & {PW{c_hit[i]}});
      hit_end   = hit_end | (c_end[i] & {(PW+1){c_hit[i]}});
      hit_prot  = hit_prot | (c_prot[i] & {3{c_hit[i]}});
    end
  end

  always_comb begin
    logic [PW+1:0] sum_f;
    logic [PW+1:0] sum_a;
    logic [PW:0]   cand;
    logic          full;
    sum_f          = {2'b00, s_r} + {1'b0, npg_r};
    cand           = c_cand[MAX_REGIONS-1];
    sum_a          = {1'b0, cand} + {1'b0, npg_r};
    full           = (count_r >= CW'(MAX_REGIONS));
    state_nxt      = state_r;
    res_status_nxt = res_status_r;
    res_addr_nxt   = res_addr_r;
    res_pte_nxt    = res_pte_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    count_nxt      = count_r;
    cell_op        = vrt_pkg::OP_NONE;
    req_page       = s_r;
    req_end        = sum_f[PW:0];
    scan_go        = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        res_status_nxt = vrt_pkg::ST_OK;
        res_addr_nxt   = '0;
        res_pte_nxt    = '0;
        state_nxt      = S_DONE;
        case (func_r)
          vrt_pkg::FN_MAP: begin
            if (size_zero_r) begin
              res_status_nxt = vrt_pkg::ST_BADSIZE;
            end else if (addr_zero_r) begin
              // launch the first-fit candidate into the chain
              scan_go   = 1'b1;
              state_nxt = S_SCAN;
            end else if (sum_f > SPAN_PG || ovl_any) begin
              res_status_nxt = vrt_pkg::ST_NOSPACE;
            end else if (full) begin
              res_status_nxt = vrt_pkg::ST_FULL;
            end else begin
              cell_op      = vrt_pkg::OP_INSERT;
              count_nxt    = count_r + CW'(1);
              res_addr_nxt = {s_r, {PS{1'b0}}};
              res_pte_nxt  = vrt_pkg::pte_of(prot_r);
            end
          end
          vrt_pkg::FN_UNMAP: begin
            if (size_zero_r) begin
              res_status_nxt = vrt_pkg::ST_BADSIZE;
            end else if (!hit_any) begin
              res_status_nxt = vrt_pkg::ST_NOTFOUND;
            end else if (s_r == hit_start && sum_f >= {1'b0, hit_end}) begin
              cell_op   = vrt_pkg::OP_DROP;
              count_nxt = count_r - CW'(1);
            end else if (s_r == hit_start) begin
              cell_op = vrt_pkg::OP_TRIM_FRONT;
            end else if (sum_f == {1'b0, hit_end}) begin
              cell_op = vrt_pkg::OP_TRIM_BACK;
            end
          end
          vrt_pkg::FN_FAULT: begin
            if (!hit_any) begin
              res_status_nxt = vrt_pkg::ST_NOTFOUND;
            end else if (wf_r && ((hit_prot & vrt_pkg::PROT_WRITE) == 3'd0)) begin
              res_status_nxt = vrt_pkg::ST_DENIED;
            end else if (pp_r) begin
              res_status_nxt = vrt_pkg::ST_MAPPED;
            end else begin
              res_addr_nxt = {s_r, {PS{1'b0}}};
              res_pte_nxt  = vrt_pkg::pte_of(hit_prot);
            end
          end
          default: begin
          end
        endcase
      end
      S_SCAN: begin
        // wait for the candidate to leave the last cell
        req_page = cand[PW-1:0];
        req_end  = sum_a[PW:0];
        if (c_tok[MAX_REGIONS-1]) begin
          state_nxt = S_DONE;
          if (sum_a >= LIM_PG) begin
            res_status_nxt = vrt_pkg::ST_NOSPACE;
          end else if (full) begin
            res_status_nxt = vrt_pkg::ST_FULL;
          end else begin
            cell_op      = vrt_pkg::OP_INSERT;
            count_nxt    = count_r + CW'(1);
            res_addr_nxt = {cand[PW-1:0], {PS{1'b0}}};
            res_pte_nxt  = vrt_pkg::pte_of(prot_r);
          end
        end
      end
      S_DONE: begin
        // hand the result over once the output slot is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
    end
    res_status_r <= res_status_nxt;
    res_addr_r   <= res_addr_nxt;
    res_pte_r    <= res_pte_nxt;
    if (in_beat) begin
      func_r      <= in_tuser;
      s_r         <= in_tdata[31:PS];
      npg_r       <= size_up[32:PS];
      prot_r      <= in_tdata[66:64];
      wf_r        <= in_tdata[67];
      pp_r        <= in_tdata[68];
      size_zero_r <= (in_tdata[63:32] == 32'd0);
      addr_zero_r <= (in_tdata[31:0] == 32'd0);
    end
    if (state_r == S_DONE && (!out_valid_r || out_tready)) begin
      out_status_r <= res_status_r;
      out_addr_r   <= res_addr_r;
      out_pte_r    <= res_pte_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_pte_r, out_addr_r, out_status_r};

endmodule

`default_nettype wire

>>> hdl/vrt_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module vrt_cell #(
  parameter int PW = 20
) (
  input  wire               clk,
  input  wire               rst_n,
  input  vrt_pkg::op_t      op,
  input  wire  [PW-1:0]     req_page,
  input  wire  [PW:0]       req_end,
  input  wire  [PW:0]       req_npg,
  input  wire  [2:0]        req_prot,
  input  wire               l_valid,
  input  wire  [PW-1:0]     l_start,
  input  wire  [PW:0]       l_end,
  input  wire  [2:0]        l_prot,
  input  wire               l_shift,
  input  wire               r_valid,
  input  wire  [PW-1:0]     r_start,
  input  wire  [PW:0]       r_end,
  input  wire  [2:0]        r_prot,
  input  wire               cand_tok_in,
  input  wire  [PW:0]       cand_in,
  output logic              cell_valid,
  output logic [PW-1:0]     cell_start,
  output logic [PW:0]       cell_end,
  output logic [2:0]        cell_prot,
  output logic              cell_shift,
  output logic              cell_hit,
  output logic              cell_ovl,
  output logic              cand_tok_out,
  output logic [PW:0]       cand_out
);

  logic            valid_r, valid_nxt;
  logic [PW-1:0]   start_r, start_nxt;
  logic [PW:0]     end_r, end_nxt;
  logic [2:0]      prot_r, prot_nxt;
  logic            tok_r;
  logic [PW:0]     cand_r, cand_nxt;
  logic [PW:0]     s_ext;
  logic            drop_sel;
  logic            cand_cov;

  assign s_ext = {1'b0, req_page};

  always_comb begin
    cell_hit   = valid_r && (start_r <= req_page) && (s_ext < end_r);
    cell_ovl   = valid_r && (s_ext < end_r) &&
                 (({1'b0, s_ext} + {1'b0, req_npg}) > {2'b00, start_r});
    cell_shift = !valid_r || (start_r >= req_page);
    drop_sel   = valid_r && (end_r > s_ext);
    // push the candidate past this region when they collide
    cand_cov   = valid_r && (cand_in < end_r) &&
                 (({1'b0, cand_in} + {1'b0, req_npg}) > {2'b00, start_r});
    cand_nxt   = cand_cov ? end_r : cand_in;
  end

  always_comb begin
    valid_nxt = valid_r;
    start_nxt = start_r;
    end_nxt   = end_r;
    prot_nxt  = prot_r;
    case (op)
      vrt_pkg::OP_INSERT: begin
        if (cell_shift) begin
          if (l_shift) begin
            valid_nxt = l_valid;
            start_nxt = l_start;
            end_nxt   = l_end;
            prot_nxt  = l_prot;
          end else begin
            valid_nxt = 1'b1;
            start_nxt = req_page;
            end_nxt   = req_end;
            prot_nxt  = req_prot;
          end
        end
      end
      vrt_pkg::OP_DROP: begin
        if (drop_sel) begin
          valid_nxt = r_valid;
          start_nxt = r_start;
          end_nxt   = r_end;
          prot_nxt  = r_prot;
        end
      end
      vrt_pkg::OP_TRIM_FRONT: begin
        if (cell_hit) begin
          start_nxt = req_end[PW-1:0];
        end
      end
      vrt_pkg::OP_TRIM_BACK: begin
        if (cell_hit) begin
          end_nxt = s_ext;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      tok_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      tok_r   <= cand_tok_in;
    end
    start_r <= start_nxt;
    end_r   <= end_nxt;
    prot_r  <= prot_nxt;
    cand_r  <= cand_nxt;
  end

  assign cell_valid   = valid_r;
  assign cell_start   = start_r;
  assign cell_end     = end_r;
  assign cell_prot    = prot_r;
  assign cand_tok_out = tok_r;
  assign cand_out     = cand_r;

endmodule

`default_nettype wire

>>> hdl/vrt_check.sv
`timescale 1ns / 1ps
`default_nettype none
`include "virtual_region_table_macros.svh"

module vrt_check (
  input wire        clk,
  input wire        rst_n,
  input wire        in_tvalid,
  input wire        in_tready,
  input wire        out_tvalid,
  input wire        out_tready,
  input wire [39:0] out_tdata
);

  // one request in flight: the input closes right after a beat
  `VRT_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_tvalid && in_tready, !in_tready)

  // a stalled result stays offered
  `VRT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)

  // status never takes the unused code
  `VRT_ASSERT_NOW(a_status_range, clk, rst_n, out_tvalid, out_tdata[2:0] <= vrt_pkg::ST_MAPPED)

  // a failed request carries no page-table flags
  `VRT_ASSERT_NOW(a_fail_no_pte, clk, rst_n, out_tvalid && out_tdata[2:0] != vrt_pkg::ST_OK, out_tdata[37:35] == 3'd0)

endmodule

bind virtual_region_table vrt_check u_vrt_check (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

>>> verif/virtual_region_table_tb.sv
`timescale 1ns / 1ps

module virtual_region_table_tb;

  localparam int NREG  = 64;
  localparam int PGSZ  = 4096;
  localparam logic [1:0] FN_UNUSED = 2'd3;

  // one request beat as the block sees it
  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] addr;
    logic [31:0] size;
    logic [2:0]  prot;
    logic        wr_fault;
    logic        present;
  } req_t;

  // one answer beat
  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] result_addr;
    logic [2:0]  page_flags;
  } rsp_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  wire         in_tready;
  logic [71:0] in_tdata;   // addr, size, prot, write_fault, page_present, pad
  logic [1:0]  in_tuser;   // func
  wire         out_tvalid;
  logic        out_tready;
  wire  [39:0] out_tdata;  // status, result_addr, page_flags, pad

  virtual_region_table u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  // shadow copy of the region table, sorted by start page
  logic [19:0] shadow_start [NREG];
  logic [20:0] shadow_end   [NREG];
  logic [2:0]  shadow_prot  [NREG];
  int          shadow_count;

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  int   n_errors;
  int   n_results;
  int   send_idle_pct;
  int   recv_stall_pct;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch on result %0d: %s got %h want %h", n_results, what, got, want);
    n_errors++;
  endtask

  function automatic int find_region(input logic [32:0] page);
    for (int i = 0; i < shadow_count; i++)
      if (page >= 33'(shadow_start[i]) && page < 33'(shadow_end[i])) return i;
    return -1;
  endfunction

  // apply one request to the shadow table and return the answer it should get
  function automatic rsp_t predict_region_op(input req_t r);
    rsp_t  a;
    logic [32:0] npg;
    logic [32:0] sp;
    logic [32:0] ep;
    logic [32:0] rs;
    logic [32:0] re;
    logic  fail;
    int    k;
    int    pos;
    a = '0;
    npg = ({1'b0, r.size} + 33'(PGSZ - 1)) / 33'(PGSZ);
    sp = {1'b0, r.addr} / 33'(PGSZ);
    case (r.func)
      vrt_pkg::FN_MAP: begin
        if (r.size == 32'd0) begin
          a.status = vrt_pkg::ST_BADSIZE;
        end else begin
          fail = 1'b0;
          if (r.addr == 32'd0) begin
            sp = 33'd1;
            for (int i = 0; i < shadow_count; i++)
              if (sp < 33'(shadow_end[i]) && sp + npg > 33'(shadow_start[i]))
                sp = 33'(shadow_end[i]);
            if ((64'(sp) + 64'(npg)) * 64'(PGSZ) > 64'(vrt_pkg::USER_LIMIT)) fail = 1'b1;
          end else begin
            if ((64'(sp) + 64'(npg)) * 64'(PGSZ) > 64'h1_0000_0000) fail = 1'b1;
            for (int i = 0; i < shadow_count; i++)
              if (sp < 33'(shadow_end[i]) && sp + npg > 33'(shadow_start[i])) fail = 1'b1;
          end
          if (fail) begin
            a.status = vrt_pkg::ST_NOSPACE;
          end else if (shadow_count >= NREG) begin
            a.status = vrt_pkg::ST_FULL;
          end else begin
            pos = 0;
            while (pos < shadow_count && shadow_start[pos] < sp[19:0]) pos++;
            for (int i = shadow_count; i > pos; i--) begin
              shadow_start[i] = shadow_start[i-1];
              shadow_end[i]   = shadow_end[i-1];
              shadow_prot[i]  = shadow_prot[i-1];
            end
            shadow_start[pos] = sp[19:0];
            ep = sp + npg;
            shadow_end[pos]   = ep[20:0];
            shadow_prot[pos]  = r.prot;
            shadow_count++;
            a.result_addr = 32'(sp[19:0]) * 32'(PGSZ);
            a.page_flags  = vrt_pkg::PTE_PRESENT |
                            (r.prot & (vrt_pkg::PROT_WRITE | vrt_pkg::PROT_USER));
          end
        end
      end
      vrt_pkg::FN_UNMAP: begin
        if (r.size == 32'd0) begin
          a.status = vrt_pkg::ST_BADSIZE;
        end else begin
          k = find_region(sp);
          if (k < 0) begin
            a.status = vrt_pkg::ST_NOTFOUND;
          end else begin
            ep = sp + npg;
            rs = 33'(shadow_start[k]);
            re = 33'(shadow_end[k]);
            if (sp == rs && ep >= re) begin
              for (int i = k; i + 1 < shadow_count; i++) begin
                shadow_start[i] = shadow_start[i+1];
                shadow_end[i]   = shadow_end[i+1];
                shadow_prot[i]  = shadow_prot[i+1];
              end
              shadow_count--;
            end else if (sp == rs) begin
              shadow_start[k] = ep[19:0];
            end else if (ep == re) begin
              shadow_end[k] = sp[20:0];
            end
          end
        end
      end
      vrt_pkg::FN_FAULT: begin
        k = find_region(sp);
        if (k < 0) begin
          a.status = vrt_pkg::ST_NOTFOUND;
        end else if (r.wr_fault && ((shadow_prot[k] & vrt_pkg::PROT_WRITE) == 3'd0)) begin
          a.status = vrt_pkg::ST_DENIED;
        end else if (r.present) begin
          a.status = vrt_pkg::ST_MAPPED;
        end else begin
          a.result_addr = 32'(sp[19:0]) * 32'(PGSZ);
          a.page_flags  = vrt_pkg::PTE_PRESENT |
                          (shadow_prot[k] & (vrt_pkg::PROT_WRITE | vrt_pkg::PROT_USER));
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  function automatic req_t make_req(input logic [1:0] f, input logic [31:0] a,
                                    input logic [31:0] s, input logic [2:0] p,
                                    input logic w, input logic pr);
    req_t r;
    r.func = f; r.addr = a; r.size = s; r.prot = p; r.wr_fault = w; r.present = pr;
    return r;
  endfunction

  // bias addresses toward the low, busy part of the space where regions sit
  function automatic logic [31:0] pick_addr();
    case ($urandom_range(0, 9))
      0:       return $urandom();
      1:       return 32'h0;
      2, 3:    return $urandom_range(0, 40) * PGSZ;
      default: return $urandom_range(0, 40 * PGSZ);
    endcase
  endfunction

  function automatic logic [31:0] pick_size();
    case ($urandom_range(0, 9))
      0:       return $urandom();
      1:       return 32'h0;
      2:       return $urandom_range(1, 4) * PGSZ;
      default: return $urandom_range(1, 6 * PGSZ);
    endcase
  endfunction

  function automatic req_t random_req();
    logic [1:0] f;
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 40)      f = vrt_pkg::FN_MAP;
    else if (sel < 65) f = vrt_pkg::FN_UNMAP;
    else if (sel < 97) f = vrt_pkg::FN_FAULT;
    else               f = FN_UNUSED;
    return make_req(f, pick_addr(), pick_size(), 3'($urandom_range(0, 7)),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endfunction

  // driver: present the head of the queue, advance on each accepted beat
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_tready) begin
      // hold the beat until taken
    end else begin
      if (in_tvalid) begin
        expected_rsps.push_back(predict_region_op(pending_reqs.pop_front()));
      end
      if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_tvalid <= 1'b1;
        in_tdata  <= {3'b0, pending_reqs[0].present, pending_reqs[0].wr_fault,
                      pending_reqs[0].prot, pending_reqs[0].size, pending_reqs[0].addr};
        in_tuser  <= pending_reqs[0].func;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // monitor: compare each accepted result beat with the oldest expectation
  always @(posedge clk) begin
    rsp_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_rsps.size() == 0) begin
          report_mismatch("unexpected beat", out_tdata[31:0], 32'h0);
        end else begin
          want = expected_rsps.pop_front();
          if (out_tdata[2:0] !== want.status)
            report_mismatch("status", 32'(out_tdata[2:0]), 32'(want.status));
          if (out_tdata[34:3] !== want.result_addr)
            report_mismatch("result_addr", out_tdata[34:3], want.result_addr);
          if (out_tdata[37:35] !== want.page_flags)
            report_mismatch("page_flags", 32'(out_tdata[37:35]), 32'(want.page_flags));
        end
        n_results++;
      end
      out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  initial begin
    #20_000_000;
    $display("timeout: %0d results, %0d still pending", n_results, expected_rsps.size());
    $display("FAIL virtual_region_table");
    $finish;
  end

  initial begin
    int lim;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
    n_errors = 0;
    n_results = 0;
    shadow_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: placement, trims, faults, boundaries and the unused code
    pending_reqs.push_back(make_req(vrt_pkg::FN_MAP, 32'h0, 32'h0, 3'd3, 1'b0, 1'b0));
    pending_reqs.push_back(make_req(vrt_pkg::FN_UNMAP, 32'h1000, 32'h0, 3'd0, 1'b0, 1'b0));
    pending_reqs.push_back(make_req(vrt_pkg::FN_FAULT, 32'h1000, 32'h1, 3'd0, 1'b1, 1'b1));
    pending_reqs.push_back(make_req(vrt_pkg::FN_MAP, 32'h0, 32'h1, 3'd7, 1'b0, 1'b0));
    pending_reqs.push_back(make_req(vrt_pkg::FN_MAP, 32'h0, 32'h3001, 3'd1, 1'b0, 1'b0));
    pending_reqs.push_back(make_req(vrt_pkg::FN_MAP, 32'h2FFF, 32'h1000, 3'd0, 1'b0, 1'b0));
    pending_reqs.push_back(make_req(vrt_pkg::FN_MAP, 32'hFFFF_F123, 32'h1000, 3'd6,
                                    1'b0, 1'b0)); // top page
    pending_reqs.push_back(make_req(vrt_pkg::FN_MAP, 32'hFFFF_F000, 32'h1001, 3'd6,
                                    1'b0, 1'b0)); // past 4G
    pending_reqs.push_back(make_req(vrt_pkg::FN_MAP, 32'h0, 32'hFFFF_FFFF, 3'd2, 1'b0, 1'b0));
    pending_reqs.push_back(make_req(vrt_pkg::FN_MAP, 32'h0, 32'hBFFF_E000, 3'd2, 1'b0, 1'b0));
    pending_reqs.push_back(make_req(vrt_pkg::FN_FAULT, 32'h2ABC, 32'h0, 3'd0, 1'b1, 1'b0));
    pending_reqs.push_back(make_req(vrt_pkg::FN_FAULT, 32'h1FFF, 32'h0, 3'd0, 1'b1, 1'b1));
    pending_reqs.push_back(make_req(vrt_pkg::FN_FAULT, 32'hFFFF_FFFF, 32'h0, 3'd0,
                                    1'b1, 1'b0)); // ok, top
    pending_reqs.push_back(make_req(vrt_pkg::FN_UNMAP, 32'h3000, 32'h1000, 3'd0,
                                    1'b0, 1'b0)); // middle
    pending_reqs.push_back(make_req(vrt_pkg::FN_UNMAP, 32'h4000, 32'h3000, 3'd0,
                                    1'b0, 1'b0)); // overrun
    pending_reqs.push_back(make_req(vrt_pkg::FN_UNMAP, 32'h2000, 32'h1000, 3'd0,
                                    1'b0, 1'b0)); // front
    pending_reqs.push_back(make_req(vrt_pkg::FN_UNMAP, 32'h5000, 32'h1000, 3'd0,
                                    1'b0, 1'b0)); // back
    pending_reqs.push_back(make_req(vrt_pkg::FN_UNMAP, 32'h1000, 32'hFFFF_FFFF, 3'd0,
                                    1'b0, 1'b0)); // remove
    pending_reqs.push_back(make_req(vrt_pkg::FN_UNMAP, 32'h1000, 32'h1, 3'd0,
                                    1'b0, 1'b0)); // not found
    pending_reqs.push_back(make_req(FN_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd7, 1'b1, 1'b1));
    // fill the table to its limit, then try past it
    for (int i = 0; i < NREG + 1; i++)
      pending_reqs.push_back(make_req(vrt_pkg::FN_MAP, 32'h0100_0000 + i * 32'h2000,
                                      32'h1000, 3'($urandom_range(0, 7)), 1'b0, 1'b0));
    pending_reqs.push_back(make_req(vrt_pkg::FN_MAP, 32'h0, 32'h1000, 3'd7, 1'b0, 1'b0));
    wait (pending_reqs.size() == 0 && expected_rsps.size() == 0);
    // empty it again so random traffic starts from a light table
    for (int i = 0; i < NREG; i++)
      pending_reqs.push_back(make_req(vrt_pkg::FN_UNMAP, 32'h0100_0000 + i * 32'h2000,
                                      32'h1000, 3'd0, 1'b0, 1'b0));

    // random phases with different idle and stall mixes
    for (int ph = 0; ph < 4; ph++) begin
      wait (pending_reqs.size() == 0 && expected_rsps.size() == 0);
      send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 10 : 53) : 0;
      recv_stall_pct = (ph == 2) ? 53 : ((ph == 3) ? 10 : 0);
      for (int i = 0; i < 425; i++) pending_reqs.push_back(random_req());
    end
    wait (pending_reqs.size() == 0 && expected_rsps.size() == 0);
    lim = 0;
    while (lim < NREG + 10) begin
      @(posedge clk);
      lim++;
    end

    $display("covered %0d result beats across map, unmap and fault requests", n_results);
    $display("four traffic mixes, table full and empty, address space edges");
    if (n_errors == 0) begin
      $display("PASS virtual_region_table");
    end else begin
      $display("FAIL virtual_region_table");
    end
    $finish;
  end

endmodule
